/* rtl/bdj_pkg.sv */
// Shared types and constants for the backoff delay generator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package bdj_pkg;

  // Field widths fixed by the interface
  localparam int unsigned AttemptW = 10;
  localparam int unsigned DelayW   = 23;
  localparam int unsigned MsW      = 22;
  localparam int unsigned GrowthW  = 13;
  localparam int unsigned JitterW  = 17;
  localparam int unsigned SeedW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Internal datapath widths (Q.8 milliseconds)
  localparam int unsigned BaseW  = MsW + 8;   // capped base delay
  localparam int unsigned AccW   = BaseW + 5; // one growth round past the cap
  localparam int unsigned RangeW = 31;
  localparam int unsigned OffW   = 32;
  localparam int unsigned SumW   = 33;
  localparam int unsigned MulW   = 32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegInitialDelay  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxDelay      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGrowthFactor  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegJitterFrac    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRandomSeed    = 3'd4;

  // Reset values
  localparam logic [MsW-1:0]     InitialDelayRst = 22'd100;
  localparam logic [MsW-1:0]     MaxDelayRst     = 22'd30000;
  localparam logic [GrowthW-1:0] GrowthRst       = 13'd512;
  localparam logic [JitterW-1:0] JitterRst       = 17'd6554;
  localparam logic [SeedW-1:0]   SeedRst         = 32'd2463534242;

  localparam logic [DelayW-1:0]  DelayMax        = 23'h7F_FFFF;
  localparam logic [SeedW-1:0]   PrngMid         = 32'h8000_0000;

  typedef struct packed {
    logic [MsW-1:0]     initial_delay;
    logic [MsW-1:0]     max_delay;
    logic [GrowthW-1:0] growth_factor;
    logic [JitterW-1:0] jitter_fraction;
    logic [SeedW-1:0]   random_seed;
  } cfg_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_GROW   = 6'b000010,
    ST_RANGE  = 6'b000100,
    ST_OFFSET = 6'b001000,
    ST_SUM    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic grow;
    logic cap_base;
    logic no_jitter;
    logic range_step;
    logic offset_step;
    logic sum;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic invalid;
    logic cnt_zero;
    logic acc_ge_cap;
    logic jit_zero;
    logic out_busy;
  } status_t;

endpackage

/* rtl/bdj_cfg_regs.sv */
// Configuration register file of the backoff delay generator.
// Depends on bdj_pkg for the register map, reset values and cfg_t.
module bdj_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdj_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bdj_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bdj_pkg::cfg_t                 cfg_o
);

  bdj_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdj_pkg::RegInitialDelay: cfg_d.initial_delay   = cfg_wdata_i[bdj_pkg::MsW-1:0];
        bdj_pkg::RegMaxDelay:     cfg_d.max_delay       = cfg_wdata_i[bdj_pkg::MsW-1:0];
        bdj_pkg::RegGrowthFactor: cfg_d.growth_factor   = cfg_wdata_i[bdj_pkg::GrowthW-1:0];
        bdj_pkg::RegJitterFrac:   cfg_d.jitter_fraction = cfg_wdata_i[bdj_pkg::JitterW-1:0];
        bdj_pkg::RegRandomSeed:   cfg_d.random_seed     = cfg_wdata_i[bdj_pkg::SeedW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_delay   <= bdj_pkg::InitialDelayRst;
      cfg_q.max_delay       <= bdj_pkg::MaxDelayRst;
      cfg_q.growth_factor   <= bdj_pkg::GrowthRst;
      cfg_q.jitter_fraction <= bdj_pkg::JitterRst;
      cfg_q.random_seed     <= bdj_pkg::SeedRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/bdj_ctrl.sv */
// Sequencing state machine of the backoff delay generator.
// Depends on bdj_pkg for state_e, cmd_t and status_t.
module bdj_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdj_pkg::status_t  status_i,
  output bdj_pkg::cmd_t     cmd_o
);

  bdj_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      bdj_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.invalid ? bdj_pkg::ST_DONE : bdj_pkg::ST_GROW;
        end
      end
      bdj_pkg::ST_GROW: begin
        if (status_i.cnt_zero || status_i.acc_ge_cap) begin
          cmd_o.cap_base = 1'b1;
          state_d        = bdj_pkg::ST_RANGE;
        end else begin
          cmd_o.grow = 1'b1;
        end
      end
      bdj_pkg::ST_RANGE: begin
        if (status_i.jit_zero) begin
          cmd_o.no_jitter = 1'b1;
          state_d         = bdj_pkg::ST_DONE;
        end else begin
          cmd_o.range_step = 1'b1;
          state_d          = bdj_pkg::ST_OFFSET;
        end
      end
      bdj_pkg::ST_OFFSET: begin
        cmd_o.offset_step = 1'b1;
        state_d           = bdj_pkg::ST_SUM;
      end
      bdj_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = bdj_pkg::ST_DONE;
      end
      bdj_pkg::ST_DONE: begin
        // hold until the output register can take the item
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = bdj_pkg::ST_IDLE;
        end
      end
      default: state_d = bdj_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdj_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == bdj_pkg::ST_IDLE);

endmodule

/* rtl/bdj_datapath.sv */
// Datapath of the backoff delay generator: shared multiplier, growth loop,
// xorshift state, jitter offset and output register. Depends on bdj_pkg.
module bdj_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bdj_pkg::cfg_t                  cfg_i,
  input  bdj_pkg::cmd_t                  cmd_i,
  output bdj_pkg::status_t               status_o,
  input  logic [bdj_pkg::AttemptW-1:0]   attempt_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bdj_pkg::DelayW-1:0]     retry_ms_o
);

  logic [bdj_pkg::AccW-1:0]      acc_q, acc_d;
  logic [bdj_pkg::AttemptW-1:0]  cnt_q, cnt_d;
  logic [bdj_pkg::BaseW-1:0]     base_q, base_d;
  logic [bdj_pkg::RangeW-1:0]    range_q, range_d;
  logic [bdj_pkg::OffW-1:0]      off_q, off_d;
  logic                          neg_q, neg_d;
  logic [bdj_pkg::SumW-1:0]      delay_q, delay_d;
  logic                          zero_q, zero_d;
  logic [bdj_pkg::SeedW-1:0]     prng_q, prng_d;
  logic                          out_valid_q, out_valid_d;
  logic [bdj_pkg::DelayW-1:0]    out_data_q, out_data_d;

  logic [bdj_pkg::BaseW-1:0]     cap;
  logic                          acc_ge_cap;
  logic [bdj_pkg::MulW-1:0]      mul_a, mul_b;
  logic [2*bdj_pkg::MulW-1:0]    prod;
  logic [bdj_pkg::SeedW-1:0]     x0, x1, x2, x3;
  logic                          prng_neg;
  logic [bdj_pkg::SeedW-1:0]     mag;
  logic                          off_gt;
  logic [bdj_pkg::SumW-8-1:0]    ms;

  assign cap        = {cfg_i.max_delay, 8'h00};
  assign acc_ge_cap = (acc_q >= {5'b0, cap});

  // One shared 32x32 multiplier, operands picked by the active step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.grow) begin
      mul_a = {2'b0, acc_q[bdj_pkg::BaseW-1:0]};
      mul_b = {19'b0, cfg_i.growth_factor};
    end else if (cmd_i.range_step) begin
      mul_a = {2'b0, base_q};
      mul_b = {15'b0, cfg_i.jitter_fraction};
    end else if (cmd_i.offset_step) begin
      mul_a = {1'b0, range_q};
      mul_b = mag;
    end
  end
  assign prod = mul_a * mul_b;

  // xorshift32, reload from seed when the state is zero
  always_comb begin
    x0 = (prng_q == '0) ? cfg_i.random_seed : prng_q;
    x1 = x0 ^ (x0 << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
  end

  // Signed distance of the state from mid scale
  assign prng_neg = !prng_q[31];
  assign mag      = prng_neg ? (bdj_pkg::PrngMid - prng_q) : {1'b0, prng_q[30:0]};
  assign off_gt   = (off_q > {2'b0, base_q});
  assign ms       = delay_q[bdj_pkg::SumW-1:8];

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    range_d     = range_q;
    off_d       = off_q;
    neg_d       = neg_q;
    delay_d     = delay_q;
    zero_d      = zero_q;
    prng_d      = prng_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    if (cmd_i.load) begin
      acc_d  = {5'b0, cfg_i.initial_delay, 8'h00};
      cnt_d  = attempt_i - 1'b1;
      zero_d = status_o.invalid;
    end
    if (cmd_i.grow) begin
      acc_d = prod[bdj_pkg::AccW+8-1:8];
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.cap_base) begin
      base_d = acc_ge_cap ? cap : acc_q[bdj_pkg::BaseW-1:0];
    end
    if (cmd_i.no_jitter) begin
      delay_d = {3'b0, base_q};
    end
    if (cmd_i.range_step) begin
      range_d = prod[bdj_pkg::RangeW+16-1:16];
      prng_d  = x3;
    end
    if (cmd_i.offset_step) begin
      off_d = prod[bdj_pkg::OffW+31-1:31];
      neg_d = prng_neg;
    end
    if (cmd_i.sum) begin
      if (neg_q) begin
        // offset past zero falls back to the cap
        delay_d = off_gt ? {3'b0, cap} : {3'b0, base_q - off_q[bdj_pkg::BaseW-1:0]};
      end else begin
        delay_d = {3'b0, base_q} + {1'b0, off_q};
      end
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      priority if (zero_q) begin
        out_data_d = '0;
      end else if (ms == '0) begin
        out_data_d = bdj_pkg::DelayW'(1);
      end else if (ms > {2'b0, bdj_pkg::DelayMax}) begin
        out_data_d = bdj_pkg::DelayMax;
      end else begin
        out_data_d = ms[bdj_pkg::DelayW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prng_q      <= bdj_pkg::SeedRst;
      out_valid_q <= 1'b0;
    end else begin
      prng_q      <= prng_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    base_q     <= base_d;
    range_q    <= range_d;
    off_q      <= off_d;
    neg_q      <= neg_d;
    delay_q    <= delay_d;
    zero_q     <= zero_d;
    out_data_q <= out_data_d;
  end

  assign status_o.invalid    = (attempt_i == '0) || (cfg_i.max_delay < cfg_i.initial_delay);
  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.acc_ge_cap = acc_ge_cap;
  assign status_o.jit_zero   = (cfg_i.jitter_fraction == '0);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign retry_ms_o  = out_data_q;

  // A growth round never starts from a value already at the cap
  a_grow_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grow |-> !acc_ge_cap)
    else $error("growth round issued at or above the cap");

  // The generator moves only on a jitter range step
  a_prng_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.range_step |=> $stable(prng_q))
    else $error("prng state changed outside a range step");

  // Never overwrite an item that is still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("output item overwritten");

  // Invalid attempt or config delivers zero
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && zero_q) |=> (out_data_q == '0))
    else $error("invalid request gave nonzero delay");

endmodule

/* rtl/backoff_delay_with_jitter.sv */
// Top level of the retry delay generator with exponential backoff and jitter.
// Depends on bdj_pkg, bdj_cfg_regs, bdj_ctrl and bdj_datapath.

// For each failed attempt number the block returns a retry delay in ms:
// initial_delay * growth_factor^(attempt-1), capped at max_delay, plus a
// random offset of up to +/- jitter_fraction of that base, drawn from an
// internal xorshift32 generator; the result is at least 1 ms and saturates
// at 8388607. An attempt of 0, or max_delay below initial_delay, returns 0
// and leaves the generator alone. One item is in flight at a time. The
// growth loop runs n = min(attempt-1, rounds until the base reaches the cap)
// rounds, n at most 1022, one round per cycle through the single shared
// 32x32 multiplier that also forms the jitter range and offset. An invalid
// request skips the growth and jitter steps; a zero jitter_fraction skips
// the range, offset and sum steps. The result sits in an output register,
// so the block returns to accepting input while that item waits to be
// taken; a second result waits in the controller until the register is
// free. Configuration writes land on the next clock edge; write them only
// while the block is idle. Writing random_seed does not disturb the
// running generator state, which reloads from the seed only when it has
// become zero.
module backoff_delay_with_jitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bdj_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bdj_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // attempt input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bdj_pkg::AttemptW-1:0]  attempt_i,
  // delay output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bdj_pkg::DelayW-1:0]    retry_ms_o
);

  bdj_pkg::cfg_t    cfg;
  bdj_pkg::cmd_t    cmd;
  bdj_pkg::status_t status;

  // Register file: delays, growth factor, jitter amplitude, seed
  bdj_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer: accept, grow, range, offset, sum, deliver
  bdj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic, generator state and output register
  bdj_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .attempt_i   (attempt_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .retry_ms_o  (retry_ms_o)
  );

endmodule
